// ----- rtl/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Shared types, codes and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package frt_pkg;

  // default bound on fragments per frame (size of the received map)
  localparam int FRT_MAX_FRAGMENTS = 1024;

  // depth of the queue between front and back, a power of two
  localparam int FRT_QUEUE_DEPTH = 4;

  // width of the frame tag kept per map entry
  localparam int FRT_TAG_W = 16;

  // stream widths
  localparam int FRT_IN_DATA_W  = 248;
  localparam int FRT_IN_USER_W  = 1;
  localparam int FRT_OUT_DATA_W = 248;
  localparam int FRT_OUT_USER_W = 4;

  // stride register reset value
  localparam logic [15:0] FRT_STRIDE_RESET = 16'd1400;

  // keyframe bit within the flags byte
  localparam logic [7:0] FRT_KEYFRAME_MASK = 8'h01;

  // word kinds on the input
  localparam logic ACT_FRAGMENT = 1'b0;
  localparam logic ACT_CLEAR    = 1'b1;

  // result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_IDX  = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_BOUNDS   = 3'd4;
  localparam logic [2:0] ST_CLEARED  = 3'd5;

  // classified fragment word passed from front to back
  typedef struct packed {
    logic        action;
    logic [31:0] sequence_req;
    logic [15:0] fragment_index;
    logic        index_over;
    logic [15:0] fragment_count;
    logic [31:0] total_size;
    logic [31:0] offset;
    logic [15:0] length;
    logic [32:0] end_sum;
    logic [7:0]  media_type;
    logic        keyframe;
    logic [63:0] timestamp;
    logic [31:0] sample_rate;
    logic [7:0]  channels;
  } frt_item_t;

  // one result word
  typedef struct packed {
    logic [2:0]  status;
    logic        prior_dropped;
    logic [15:0] dropped_got;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic [31:0] done_sequence;
    logic [7:0]  done_media_type;
    logic [63:0] done_timestamp;
    logic        done_keyframe;
    logic [31:0] done_sample_rate;
    logic [7:0]  done_channels;
    logic [31:0] done_total_size;
  } frt_result_t;

endpackage

`default_nettype wire

// ----- rtl/frt_front.sv -----
// ----------------------------------------------------------------------------
// frt_front
// Input side: unpacks the word, holds the stride register, forms the write
// offset, the copy length and the payload end, and flags indexes past the map.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_front #(
  parameter int MAX_FRAGMENTS = frt_pkg::FRT_MAX_FRAGMENTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [15:0]                      cfg_wr_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [frt_pkg::FRT_IN_DATA_W-1:0] s_tdata,
  input  wire logic [frt_pkg::FRT_IN_USER_W-1:0] s_tuser,
  output frt_pkg::frt_item_t                    item,
  output logic                                  item_valid,
  input  wire logic                             item_ready
);
  import frt_pkg::*;

  localparam logic [16:0] INDEX_LIMIT = 17'(MAX_FRAGMENTS);

  logic [15:0] fragment_stride;
  logic        f1_valid;
  frt_item_t   f1_item;
  logic        accept;

  logic [15:0] in_index;
  logic [15:0] in_hlen;
  logic [15:0] in_alen;

  // stride register
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_stride <= FRT_STRIDE_RESET;
    end else if (cfg_wr_en) begin
      fragment_stride <= cfg_wr_data;
    end
  end

  assign s_tready = !f1_valid || item_ready;
  assign accept   = s_tvalid && s_tready;

  assign in_index = s_tdata[47:32];
  assign in_hlen  = s_tdata[111:96];
  assign in_alen  = s_tdata[127:112];

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= 1'b1;
    end else if (item_ready) begin
      f1_valid <= 1'b0;
    end
  end

  // unpack, multiply and classify
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_item.action         <= s_tuser[0];
      f1_item.sequence_req   <= s_tdata[31:0];
      f1_item.fragment_index <= in_index;
      f1_item.index_over     <= ({1'b0, in_index} >= INDEX_LIMIT);
      f1_item.fragment_count <= s_tdata[63:48];
      f1_item.total_size     <= s_tdata[95:64];
      f1_item.offset         <= {16'd0, in_index} * {16'd0, fragment_stride};
      f1_item.length         <= (in_alen < in_hlen) ? in_alen : in_hlen;
      f1_item.end_sum        <= '0;
      f1_item.media_type     <= s_tdata[135:128];
      f1_item.keyframe       <= |(s_tdata[143:136] & FRT_KEYFRAME_MASK);
      f1_item.timestamp      <= s_tdata[207:144];
      f1_item.sample_rate    <= s_tdata[239:208];
      f1_item.channels       <= s_tdata[247:240];
    end
  end

  // payload end, computed without wrap
  always_comb begin
    item         = f1_item;
    item.end_sum = {1'b0, f1_item.offset} + {17'd0, f1_item.length};
  end

  assign item_valid = f1_valid;

endmodule

`default_nettype wire

// ----- rtl/frt_queue.sv -----
// ----------------------------------------------------------------------------
// frt_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire frt_pkg::frt_item_t in_item,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output frt_pkg::frt_item_t      out_item,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import frt_pkg::*;

  localparam int PW = $clog2(FRT_QUEUE_DEPTH);
  localparam logic [PW:0] FULL_COUNT = (PW + 1)'(FRT_QUEUE_DEPTH);

  frt_item_t   entries [FRT_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != FULL_COUNT);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/frt_back.sv -----
// ----------------------------------------------------------------------------
// frt_back
// Execution side: reads the received map, keeps the pending frame, decides
// the status of each word and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module frt_back #(
  parameter int MAX_FRAGMENTS = frt_pkg::FRT_MAX_FRAGMENTS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire frt_pkg::frt_item_t                 item,
  input  wire logic                               item_valid,
  output logic                                    item_ready,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [frt_pkg::FRT_OUT_DATA_W-1:0]      m_tdata,
  output logic [frt_pkg::FRT_OUT_USER_W-1:0]      m_tuser
);
  import frt_pkg::*;

  localparam int AW = $clog2(MAX_FRAGMENTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAGMENTS - 1);

  localparam logic BK_SWEEP = 1'b0;
  localparam logic BK_RUN   = 1'b1;

  // map of frame tags, one per fragment slot
  logic [FRT_TAG_W-1:0] tag_mem [MAX_FRAGMENTS];

  logic                 state;
  logic [AW-1:0]        sweep_ptr;
  logic [FRT_TAG_W-1:0] epoch;

  logic                 b1_valid;
  frt_item_t            b1_item;
  logic                 b2_valid;
  frt_item_t            b2_item;
  logic [FRT_TAG_W-1:0] rd_tag;
  logic                 fwd_hit;
  logic [FRT_TAG_W-1:0] fwd_tag;

  logic                 pending_valid;
  logic [31:0]          pend_sequence;
  logic [7:0]           pend_media_type;
  logic [63:0]          pend_timestamp;
  logic [31:0]          pend_total_size;
  logic [15:0]          pend_fragment_count;
  logic                 pend_keyframe;
  logic [31:0]          pend_sample_rate;
  logic [7:0]           pend_channels;
  logic [15:0]          received_total;

  frt_result_t          res;
  frt_result_t          out_res;

  logic                 sweeping;
  logic                 out_free;
  logic                 is_clear;
  logic                 new_frame;
  logic                 wrap_hold;
  logic                 b2_fire;
  logic                 b2_free;
  logic                 b1_adv;
  logic [15:0]          cur_count;
  logic [31:0]          cur_size;
  logic [15:0]          cur_total;
  logic [15:0]          total_inc;
  logic [FRT_TAG_W-1:0] cur_epoch;
  logic [FRT_TAG_W-1:0] stored_tag;
  logic                 seen;
  logic                 bad_index;
  logic                 beyond;
  logic                 complete;
  logic                 dropped;
  logic                 store;
  logic [AW-1:0]        b1_addr;
  logic [AW-1:0]        b2_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [FRT_TAG_W-1:0] mem_wdata;

  // pipeline control
  assign sweeping   = (state == BK_SWEEP);
  assign out_free   = !m_tvalid || m_tready;
  assign is_clear   = (b2_item.action == ACT_CLEAR);
  assign new_frame  = !pending_valid || (pend_sequence != b2_item.sequence_req);
  assign wrap_hold  = !sweeping && b2_valid && !is_clear && new_frame && (epoch == '1);
  assign b2_fire    = b2_valid && !sweeping && !wrap_hold && out_free;
  assign b2_free    = !b2_valid || b2_fire;
  assign b1_adv     = b1_valid && b2_free && !sweeping;
  assign item_ready = !b1_valid || b1_adv;

  assign b1_addr = b1_item.fragment_index[AW-1:0];
  assign b2_addr = b2_item.fragment_index[AW-1:0];

  // view of the frame this word belongs to
  assign cur_count  = new_frame ? b2_item.fragment_count : pend_fragment_count;
  assign cur_size   = new_frame ? b2_item.total_size : pend_total_size;
  assign cur_total  = new_frame ? 16'd0 : received_total;
  assign cur_epoch  = new_frame ? epoch + 1'b1 : epoch;
  assign total_inc  = cur_total + 16'd1;
  assign stored_tag = fwd_hit ? fwd_tag : rd_tag;

  // checks
  assign seen      = !new_frame && (stored_tag == epoch);
  assign bad_index = b2_item.index_over || (b2_item.fragment_index >= cur_count);
  assign beyond    = b2_item.end_sum > {1'b0, cur_size};
  assign complete  = (total_inc == cur_count);
  assign dropped   = new_frame && pending_valid && (received_total < pend_fragment_count);
  assign store     = b2_fire && !is_clear && !bad_index && !seen && !beyond;

  // map write port, shared by the clearing pass and stored fragments
  assign mem_we    = sweeping || store;
  assign mem_waddr = sweeping ? sweep_ptr : b2_addr;
  assign mem_wdata = sweeping ? '0 : cur_epoch;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    if (b1_adv) begin
      rd_tag <= tag_mem[b1_addr];
    end
  end

  // bypass for a write to the slot being read in the same cycle
  always_ff @(posedge clk) begin
    if (b1_adv) begin
      fwd_hit <= store && (b2_addr == b1_addr);
      fwd_tag <= cur_epoch;
    end
  end

  // clearing pass after reset and whenever the frame tag wraps
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_SWEEP;
      sweep_ptr <= '0;
      epoch     <= '0;
    end else begin
      unique case (state)
        BK_SWEEP: begin
          sweep_ptr <= sweep_ptr + 1'b1;
          if (sweep_ptr == LAST_ADDR) begin
            state <= BK_RUN;
            epoch <= '0;
          end
        end
        BK_RUN: begin
          if (wrap_hold) begin
            state     <= BK_SWEEP;
            sweep_ptr <= '0;
          end else if (b2_fire && !is_clear && new_frame) begin
            epoch <= epoch + 1'b1;
          end
        end
        default: begin
          state <= BK_SWEEP;
        end
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        b1_valid <= 1'b1;
      end else if (b1_adv) begin
        b1_valid <= 1'b0;
      end
      if (b1_adv) begin
        b2_valid <= 1'b1;
      end else if (b2_fire) begin
        b2_valid <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      b1_item <= item;
    end
    if (b1_adv) begin
      b2_item <= b1_item;
    end
  end

  // pending frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid  <= 1'b0;
      received_total <= '0;
    end else if (b2_fire) begin
      if (is_clear) begin
        pending_valid <= 1'b0;
      end else begin
        if (new_frame) begin
          pending_valid  <= 1'b1;
          received_total <= '0;
        end
        if (store) begin
          received_total <= total_inc;
          if (complete) begin
            pending_valid <= 1'b0;
          end
        end
      end
    end
  end

  // metadata of the pending frame
  always_ff @(posedge clk) begin
    if (b2_fire && !is_clear && new_frame) begin
      pend_sequence       <= b2_item.sequence_req;
      pend_media_type     <= b2_item.media_type;
      pend_timestamp      <= b2_item.timestamp;
      pend_total_size     <= b2_item.total_size;
      pend_fragment_count <= b2_item.fragment_count;
      pend_keyframe       <= b2_item.keyframe;
      pend_sample_rate    <= b2_item.sample_rate;
      pend_channels       <= b2_item.channels;
    end
  end

  // result word
  always_comb begin
    res = '0;
    if (is_clear) begin
      res.status = ST_CLEARED;
    end else begin
      res.prior_dropped = dropped;
      res.dropped_got   = dropped ? received_total : 16'd0;
      if (bad_index) begin
        res.status = ST_BAD_IDX;
      end else if (seen) begin
        res.status = ST_DUP;
      end else begin
        res.write_offset = b2_item.offset;
        res.write_length = b2_item.length;
        if (beyond) begin
          res.status = ST_BOUNDS;
        end else if (complete) begin
          res.status           = ST_COMPLETE;
          res.done_sequence    = b2_item.sequence_req;
          res.done_media_type  = new_frame ? b2_item.media_type : pend_media_type;
          res.done_timestamp   = new_frame ? b2_item.timestamp : pend_timestamp;
          res.done_keyframe    = new_frame ? b2_item.keyframe : pend_keyframe;
          res.done_sample_rate = new_frame ? b2_item.sample_rate : pend_sample_rate;
          res.done_channels    = new_frame ? b2_item.channels : pend_channels;
          res.done_total_size  = cur_size;
        end else begin
          res.status = ST_STORED;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b2_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_fire) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0,
                    out_res.done_total_size,
                    out_res.done_channels,
                    out_res.done_sample_rate,
                    out_res.done_keyframe,
                    out_res.done_timestamp,
                    out_res.done_media_type,
                    out_res.done_sequence,
                    out_res.write_length,
                    out_res.write_offset,
                    out_res.dropped_got};
  assign m_tuser = {out_res.prior_dropped, out_res.status};

endmodule

`default_nettype wire

// ----- rtl/fragment_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks reassembly of one pending frame from fragment descriptors.
// ----------------------------------------------------------------------------
// Takes one fragment descriptor or clear request per word and gives one result
// word for each, one word per clock when both sides keep moving and no
// clearing pass runs. A word passes the input stage (offset multiply), a
// four-word queue, the map read stage and the execute stage, and its result
// is then held in the output register. The received map is a tag memory of
// MAX_FRAGMENTS entries with one registered read and one write per clock.
// After reset the block runs a clearing pass over all MAX_FRAGMENTS entries of
// that memory before it takes words (up to six words are accepted meanwhile,
// four of them in the queue); the same pass runs again each time the 16-bit
// frame tag wraps, that is once every 65535 opened frames, and stalls the back
// end while it runs. The stride register may be written only while no word is
// in flight.
`default_nettype none

module fragment_reassembly_tracker #(
  parameter int MAX_FRAGMENTS = frt_pkg::FRT_MAX_FRAGMENTS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // stride register write
  input  wire logic                               cfg_wr_en,
  input  wire logic [15:0]                        cfg_wr_data,
  // descriptor stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // sequence_req, fragment_index, fragment_count, total_size, header_payload_len,
  // arrived_payload_len, media_type, flags, timestamp, sample_rate, channels
  input  wire logic [frt_pkg::FRT_IN_DATA_W-1:0]  s_tdata,
  // action
  input  wire logic [frt_pkg::FRT_IN_USER_W-1:0]  s_tuser,
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // dropped_got, write_offset, write_length, done_sequence, done_media_type,
  // done_timestamp, done_keyframe, done_sample_rate, done_channels,
  // done_total_size, zero fill
  output logic [frt_pkg::FRT_OUT_DATA_W-1:0]      m_tdata,
  // status, prior_dropped
  output logic [frt_pkg::FRT_OUT_USER_W-1:0]      m_tuser
);
  import frt_pkg::*;

  frt_item_t front_item;
  logic      front_valid;
  logic      front_ready;
  frt_item_t queue_item;
  logic      queue_valid;
  logic      queue_ready;

  // input stage
  frt_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  // decoupling queue
  frt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_item  (front_item),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .out_item (queue_item),
    .out_valid(queue_valid),
    .out_ready(queue_ready)
  );

  // map, pending frame and results
  frt_back #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .item      (queue_item),
    .item_valid(queue_valid),
    .item_ready(queue_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire
